// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AWP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define AWP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- sv/awp_pkg.sv -----
package awp_pkg;

    // Default sizes of the index and rank datapaths
    localparam int INDEX_BITS_DEF = 32;
    localparam int RANK_BITS_DEF  = 16;

    // Fixed field widths
    localparam int TOTAL_W    = 32;
    localparam int RANKS_W    = 16;
    localparam int MODE_W     = 2;
    localparam int RATIO_W    = 17;
    localparam int FRAC_BITS  = 16;
    localparam int RANK_OUT_W = 16;
    localparam int START_W    = 32;
    localparam int COUNT_W    = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Sequencer step counts
    localparam int DIV_STEPS = TOTAL_W;
    localparam int MUL_STEPS = RATIO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_COUNT     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RANK_COUNT      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPLIT_MODE      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SHARE_RATIO = 2'd3;

    // Split modes; the unused code behaves as even mode
    localparam logic [MODE_W-1:0] MODE_ALIGNED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EVEN      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVEN_LAST = 2'd2;

    // Register reset values
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;
    localparam logic [RANKS_W-1:0] RANKS_RESET = 16'd1;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd65536;

    // Controller to datapath commands
    typedef struct packed {
        logic div_start;
        logic div_step;
        logic part_init;
        logic mul_start;
        logic mul_step;
        logic clr_step;
        logic out_load;
        logic past;
    } awp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic finished;
        logic last;
        logic aligned;
        logic clr_go;
        logic out_free;
    } awp_status_t;

endpackage

// ----- sv/awp_ctrl.sv -----
module awp_ctrl
    import awp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  awp_status_t status,
    output awp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_INIT   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_CLR    = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              past_reg, past_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencing of one request
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        past_next  = past_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        cmd.div_start = 1'b1;
                        cnt_next      = '0;
                        past_next     = 1'b0;
                        state_next    = ST_DIV;
                    end
                    else if (status.finished)
                    begin
                        past_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        past_next  = 1'b0;
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.part_init = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!status.last && status.aligned)
                begin
                    cmd.mul_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_MUL;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                if (status.clr_go)
                begin
                    cmd.clr_step = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.past = past_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            past_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            past_reg  <= past_next;
        end
    end

endmodule

// ----- sv/awp_datapath.sv -----
module awp_datapath
    import awp_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int RANK_BITS  = RANK_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  awp_cmd_t              cmd,
    output awp_status_t           status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [RANK_OUT_W-1:0] rank_index,
    output logic [START_W-1:0]    start_index,
    output logic [COUNT_W-1:0]    slice_count,
    output logic                  last_rank,
    output logic                  past_end
);

    localparam int PROD_W = INDEX_BITS + RATIO_W;
    localparam int CMP_W  = (RANK_BITS > RANKS_W) ? RANK_BITS + 1 : RANKS_W + 1;
    localparam int LW     = (INDEX_BITS > RANK_BITS) ? INDEX_BITS : RANK_BITS;

    // Configuration registers
    logic [TOTAL_W-1:0] total_count_reg;
    logic [RANKS_W-1:0] rank_count_reg;
    logic [MODE_W-1:0]  split_mode_reg;
    logic [RATIO_W-1:0] ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg <= TOTAL_RESET;
            rank_count_reg  <= RANKS_RESET;
            split_mode_reg  <= MODE_ALIGNED;
            ratio_reg       <= RATIO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TOTAL_COUNT:     total_count_reg <= cfg_wdata[TOTAL_W-1:0];
                REG_RANK_COUNT:      rank_count_reg  <= cfg_wdata[RANKS_W-1:0];
                REG_SPLIT_MODE:      split_mode_reg  <= cfg_wdata[MODE_W-1:0];
                REG_MIN_SHARE_RATIO: ratio_reg       <= cfg_wdata[RATIO_W-1:0];
                default:             ;
            endcase
        end
    end

    // A rank count of zero counts as one
    logic [RANKS_W-1:0] ranks;
    assign ranks = (rank_count_reg == '0) ? RANKS_W'(1) : rank_count_reg;

    // Restoring divider, one quotient bit per step
    logic [RANKS_W-1:0] rem_reg;
    logic [TOTAL_W-1:0] quo_reg;
    logic [RANKS_W:0]   trial;
    logic [RANKS_W:0]   trial_diff;
    logic               trial_fits;

    assign trial      = {rem_reg, quo_reg[TOTAL_W-1]};
    assign trial_fits = (trial >= {1'b0, ranks});
    assign trial_diff = trial - {1'b0, ranks};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= total_count_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_fits ? trial_diff[RANKS_W-1:0] : trial[RANKS_W-1:0];
            quo_reg <= {quo_reg[TOTAL_W-2:0], trial_fits};
        end
    end

    // Partition state
    logic [RANK_BITS-1:0]  next_rank_reg;
    logic [INDEX_BITS-1:0] cur_start_reg;
    logic [INDEX_BITS-1:0] fair_reg;
    logic [INDEX_BITS-1:0] left_reg;
    logic                  finished_reg;

    // Shift-add multiplier for ratio times fair share, ratio MSB first
    logic [PROD_W-1:0]  prod_reg;
    logic [RATIO_W-1:0] ratio_sh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            prod_reg     <= '0;
            ratio_sh_reg <= ratio_reg;
        end
        else if (cmd.mul_step)
        begin
            prod_reg     <= {prod_reg[PROD_W-2:0], 1'b0}
                            + (ratio_sh_reg[RATIO_W-1] ? PROD_W'(fair_reg) : PROD_W'(0));
            ratio_sh_reg <= {ratio_sh_reg[RATIO_W-2:0], 1'b0};
        end
    end

    // Lowest-set-bit clearing of the proposed start
    logic [INDEX_BITS-1:0] prop_reg;
    logic [INDEX_BITS-1:0] best_reg;
    logic [INDEX_BITS-1:0] span;
    logic [PROD_W-1:0]     limit;
    logic                  clr_go;

    assign span   = prop_reg - cur_start_reg;
    assign limit  = PROD_W'({span, {FRAC_BITS{1'b0}}});
    assign clr_go = (cur_start_reg < prop_reg) && (prod_reg <= limit);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            prop_reg <= cur_start_reg + fair_reg;
            best_reg <= cur_start_reg + fair_reg;
        end
        else if (cmd.clr_step)
        begin
            best_reg <= prop_reg;
            prop_reg <= prop_reg & (prop_reg - INDEX_BITS'(1));
        end
    end

    // Slice of the current rank
    logic [CMP_W-1:0]      rank_plus;
    logic                  is_last;
    logic                  extra;
    logic [INDEX_BITS-1:0] total_ix;
    logic [INDEX_BITS-1:0] count;
    logic [INDEX_BITS-1:0] next_start;

    assign rank_plus = CMP_W'(next_rank_reg) + CMP_W'(1);
    assign is_last   = (rank_plus >= CMP_W'(ranks));
    assign extra     = (LW'(next_rank_reg) < LW'(left_reg));
    assign total_ix  = INDEX_BITS'(total_count_reg);

    always_comb
    begin
        if (is_last)
        begin
            count      = total_ix - cur_start_reg;
            next_start = cur_start_reg;
        end
        else
        begin
            case (split_mode_reg)
                MODE_ALIGNED:
                begin
                    count      = best_reg - cur_start_reg;
                    next_start = best_reg;
                end
                MODE_EVEN_LAST:
                begin
                    count      = fair_reg;
                    next_start = cur_start_reg + fair_reg;
                end
                default:
                begin
                    count      = fair_reg + INDEX_BITS'(extra);
                    next_start = cur_start_reg + count;
                end
            endcase
        end
    end

    // State update at restart and after each reported rank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_rank_reg <= '0;
            cur_start_reg <= '0;
            fair_reg      <= '0;
            left_reg      <= '0;
            finished_reg  <= 1'b1;
        end
        else if (cmd.part_init)
        begin
            next_rank_reg <= '0;
            cur_start_reg <= '0;
            fair_reg      <= INDEX_BITS'(quo_reg);
            left_reg      <= INDEX_BITS'(rem_reg);
            finished_reg  <= 1'b0;
        end
        else if (cmd.out_load && !cmd.past)
        begin
            if (is_last)
            begin
                finished_reg <= 1'b1;
            end
            else
            begin
                next_rank_reg <= next_rank_reg + RANK_BITS'(1);
                cur_start_reg <= next_start;
            end
        end
    end

    // Output register
    logic                  out_valid_reg;
    logic [RANK_OUT_W-1:0] rank_out_reg;
    logic [START_W-1:0]    start_out_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    logic                  last_out_reg;
    logic                  past_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.past)
            begin
                rank_out_reg  <= '0;
                start_out_reg <= '0;
                count_out_reg <= '0;
                last_out_reg  <= 1'b0;
                past_out_reg  <= 1'b1;
            end
            else
            begin
                rank_out_reg  <= RANK_OUT_W'(next_rank_reg);
                start_out_reg <= START_W'(cur_start_reg);
                count_out_reg <= COUNT_W'(count);
                last_out_reg  <= is_last;
                past_out_reg  <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign rank_index  = rank_out_reg;
    assign start_index = start_out_reg;
    assign slice_count = count_out_reg;
    assign last_rank   = last_out_reg;
    assign past_end    = past_out_reg;

    // Status back to the controller
    assign status.finished = finished_reg;
    assign status.last     = is_last;
    assign status.aligned  = (split_mode_reg == MODE_ALIGNED);
    assign status.clr_go   = clr_go;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// ----- sv/aligned_work_partitioner_core.sv -----
// Sequence: an advance passes DECIDE and EMIT before out_valid is registered; a past_end report
// goes straight to EMIT; a restart first runs the divider steps and INIT. Aligned mode, on a rank
// other than the last, adds 17 multiplier steps, a clearing step per cleared bit and a final check.
// One request at a time: in_ready stays low until EMIT, which waits for a free output, loads it.
// Reset (rst_n low, asynchronous): registers to their defaults, no output pending,
// partition finished so an advance reports past_end until a restart is taken.
module aligned_work_partitioner_core
    import awp_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int RANK_BITS  = RANK_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RANK_OUT_W-1:0] rank_index,
    output logic [START_W-1:0]    start_index,
    output logic [COUNT_W-1:0]    slice_count,
    output logic                  last_rank,
    output logic                  past_end
);

    awp_cmd_t    cmd;
    awp_status_t status;

    awp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .status   (status),
        .cmd      (cmd)
    );

    awp_datapath #(
        .INDEX_BITS (INDEX_BITS),
        .RANK_BITS  (RANK_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .rank_index  (rank_index),
        .start_index (start_index),
        .slice_count (slice_count),
        .last_rank   (last_rank),
        .past_end    (past_end)
    );

endmodule

// ----- sv/awp_checker.sv -----
`include "assert_macros.svh"

module awp_checker
    import awp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [RANK_OUT_W-1:0] rank_index,
    input logic [START_W-1:0]    start_index,
    input logic [COUNT_W-1:0]    slice_count,
    input logic                  last_rank,
    input logic                  past_end
);

    // Nothing pending and ready for a request once reset has been seen at an edge
    `AWP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "busy in reset")

    // One request in flight: ready drops right after an accept
    `AWP_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "ready held after accept")

    // A past-end report carries no slice
    `AWP_ASSERT(a_past_end_empty, out_valid && past_end |-> rank_index == '0 && start_index == '0 && slice_count == '0 && !last_rank, "past_end with slice data")

    // A stalled result holds
    `AWP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(start_index) && $stable(slice_count) && $stable(rank_index), "stalled result changed")

endmodule

bind aligned_work_partitioner_core awp_checker u_awp_checker (.*);
